[rtl/core/mips_subset_execute_core_assert.svh]
// Assertion macros shared by the core's modules.
// Each takes a label, the clock, the active-low reset, the property
// terms and a message string.
`ifndef MIPS_SUBSET_EXECUTE_CORE_ASSERT_SVH
`define MIPS_SUBSET_EXECUTE_CORE_ASSERT_SVH

`ifndef SYNTHESIS

`define MSEC_ASSERT_IMPL(lbl, clk, rst_n, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

`define MSEC_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`else

`define MSEC_ASSERT_IMPL(lbl, clk, rst_n, pre, post, msg)

`define MSEC_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg)

`endif

`endif

[rtl/core/msx_pkg.sv]
`timescale 1ns / 1ps

package msx_pkg;

    localparam int WORD_W  = 32;
    localparam int REG_W   = 5;
    localparam int REG_NUM = 32;

    localparam logic [WORD_W-1:0] PC_RESET = 32'h0040_0000;

    // Opcodes
    localparam logic [5:0] OP_RTYPE = 6'b000000;
    localparam logic [5:0] OP_J     = 6'b000010;
    localparam logic [5:0] OP_BEQ   = 6'b000100;
    localparam logic [5:0] OP_BNE   = 6'b000101;

    // R-type functs
    localparam logic [5:0] FN_ADD = 6'd32;
    localparam logic [5:0] FN_SUB = 6'd34;
    localparam logic [5:0] FN_AND = 6'd36;
    localparam logic [5:0] FN_OR  = 6'd37;
    localparam logic [5:0] FN_SLT = 6'd42;

    typedef struct packed {
        logic [WORD_W-1:0] next_pc;
        logic              reg_written;
        logic [REG_W-1:0]  dest_reg;
        logic [WORD_W-1:0] write_value;
        logic              unsupported;
    } exec_res_t;

    typedef struct packed {
        logic              en;
        logic [REG_W-1:0]  addr;
        logic [WORD_W-1:0] data;
    } rf_write_t;

endpackage

[rtl/core/msx_if.sv]
`timescale 1ns / 1ps

interface msx_instr_if;
    logic                        valid;
    logic                        ready;
    logic [msx_pkg::WORD_W-1:0]  instr_word;

    modport source (output valid, output instr_word, input ready);
    modport sink   (input valid, input instr_word, output ready);
endinterface

interface msx_result_if;
    logic                              valid;
    logic                              ready;
    logic [msx_pkg::WORD_W-1:0]        next_pc;
    logic                              reg_written;
    logic [msx_pkg::REG_W-1:0]         dest_reg;
    logic signed [msx_pkg::WORD_W-1:0] write_value;
    logic                              unsupported;

    modport source (output valid, output next_pc, output reg_written, output dest_reg,
                    output write_value, output unsupported, input ready);
    modport sink   (input valid, input next_pc, input reg_written, input dest_reg,
                    input write_value, input unsupported, output ready);
endinterface

[rtl/core/msx_regfile.sv]
`timescale 1ns / 1ps
`include "mips_subset_execute_core_assert.svh"

module msx_regfile (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        rd_en,
    input  logic [msx_pkg::REG_W-1:0]   rd_addr_a,
    input  logic [msx_pkg::REG_W-1:0]   rd_addr_b,
    output logic [msx_pkg::WORD_W-1:0]  rd_data_a,
    output logic [msx_pkg::WORD_W-1:0]  rd_data_b,
    input  msx_pkg::rf_write_t          wr
);
    import msx_pkg::*;

    logic [WORD_W-1:0]  mem [REG_NUM];
    logic [REG_NUM-1:0] valid_reg;
    logic [REG_NUM-1:0] valid_next;

    logic [WORD_W-1:0]  raw_a_reg;
    logic [WORD_W-1:0]  raw_b_reg;
    logic [WORD_W-1:0]  fwd_data_reg;
    logic               fwd_a_reg;
    logic               fwd_b_reg;
    logic               zero_a_reg;
    logic               zero_b_reg;

    logic               fwd_a;
    logic               fwd_b;
    logic               zero_a;
    logic               zero_b;

    // A write landing on the same edge as a read wins over the stored value.
    assign fwd_a  = wr.en && (wr.addr == rd_addr_a) && (rd_addr_a != '0);
    assign fwd_b  = wr.en && (wr.addr == rd_addr_b) && (rd_addr_b != '0);
    // Register zero and never-written entries read as zero.
    assign zero_a = (rd_addr_a == '0) || !valid_reg[rd_addr_a];
    assign zero_b = (rd_addr_b == '0) || !valid_reg[rd_addr_b];

    always_comb
    begin
        valid_next = valid_reg;
        if (wr.en)
        begin
            valid_next[wr.addr] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            fwd_a_reg  <= 1'b0;
            fwd_b_reg  <= 1'b0;
            zero_a_reg <= 1'b1;
            zero_b_reg <= 1'b1;
        end
        else
        begin
            valid_reg <= valid_next;
            if (rd_en)
            begin
                fwd_a_reg  <= fwd_a;
                fwd_b_reg  <= fwd_b;
                zero_a_reg <= zero_a;
                zero_b_reg <= zero_b;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        if (rd_en)
        begin
            raw_a_reg    <= mem[rd_addr_a];
            raw_b_reg    <= mem[rd_addr_b];
            fwd_data_reg <= wr.data;
        end
    end

    assign rd_data_a = fwd_a_reg ? fwd_data_reg : (zero_a_reg ? '0 : raw_a_reg);
    assign rd_data_b = fwd_b_reg ? fwd_data_reg : (zero_b_reg ? '0 : raw_b_reg);

    `MSEC_ASSERT_IMPL(a_rf_no_zero_write, clk, rst_n, wr.en, wr.addr != '0, "write to register zero")

endmodule

[rtl/core/msx_exec.sv]
`timescale 1ns / 1ps

module msx_exec (
    input  logic [msx_pkg::WORD_W-1:0] instr_word,
    input  logic [msx_pkg::WORD_W-1:0] pc,
    input  logic [msx_pkg::WORD_W-1:0] op_a,
    input  logic [msx_pkg::WORD_W-1:0] op_b,
    output msx_pkg::exec_res_t         res
);
    import msx_pkg::*;

    logic [5:0]        opcode;
    logic [5:0]        funct;
    logic [REG_W-1:0]  rd;
    logic [WORD_W-1:0] pc4;
    logic [WORD_W-1:0] br_offset;
    logic [WORD_W-1:0] br_target;
    logic [WORD_W-1:0] alu_val;
    logic              alu_ok;
    logic              ops_equal;
    logic              take;

    assign opcode    = instr_word[31:26];
    assign funct     = instr_word[5:0];
    assign rd        = instr_word[15:11];
    assign pc4       = pc + WORD_W'(4);
    assign br_offset = {{14{instr_word[15]}}, instr_word[15:0], 2'b00};
    assign br_target = pc4 + br_offset;
    assign ops_equal = (op_a == op_b);

    always_comb
    begin
        alu_ok = 1'b1;
        unique case (funct)
            FN_ADD:  alu_val = op_a + op_b;
            FN_SUB:  alu_val = op_a - op_b;
            FN_AND:  alu_val = op_a & op_b;
            FN_OR:   alu_val = op_a | op_b;
            FN_SLT:  alu_val = {{(WORD_W-1){1'b0}}, ($signed(op_a) < $signed(op_b))};
            default:
            begin
                alu_val = '0;
                alu_ok  = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        res             = '0;
        res.next_pc     = pc4;
        take            = 1'b0;
        unique case (opcode) inside
            OP_RTYPE:
            begin
                if (!alu_ok)
                begin
                    res.unsupported = 1'b1;
                end
                else if (rd != '0)
                begin
                    res.reg_written = 1'b1;
                    res.dest_reg    = rd;
                    res.write_value = alu_val;
                end
            end
            OP_BEQ, OP_BNE:
            begin
                take = (opcode == OP_BEQ) ? ops_equal : !ops_equal;
                if (take)
                begin
                    res.next_pc = br_target;
                end
            end
            OP_J:
            begin
                res.next_pc = {pc4[31:28], instr_word[25:0], 2'b00};
            end
            default:
            begin
                res.unsupported = 1'b1;
            end
        endcase
    end

endmodule

[rtl/core/mips_subset_execute_core.sv]
`timescale 1ns / 1ps
// Channel   Modport  Payload                                                Dir
// --------  -------  -----------------------------------------------------  ---
// instr     sink     instr_word[31:0]                                       in
// result    source   next_pc, reg_written, dest_reg, write_value,           out
//                    unsupported
//
// One instruction per cycle sustained while results are taken; a result passes
// through the register read stage, then execute into the output register.
// The register file is a synchronous two-read, one-write memory; a write on
// the same edge as a read is forwarded, so back-to-back dependent
// instructions need no bubble. Reset clears pc to 0x400000 and the entry
// valid bits, so every register reads zero; no clearing pass is needed.
// A stalled result holds the execute stage, which then holds the input.
`include "mips_subset_execute_core_assert.svh"

module mips_subset_execute_core (
    input  logic          clk,
    input  logic          rst_n,
    msx_instr_if.sink     instr,
    msx_result_if.source  result
);
    import msx_pkg::*;

    // Read stage -> execute stage
    logic              s1_valid_reg;
    logic              s1_valid_next;
    logic [WORD_W-1:0] s1_instr_reg;

    // Program counter, updated when an instruction leaves execute
    logic [WORD_W-1:0] pc_reg;
    logic [WORD_W-1:0] pc_next;

    // Output register
    logic              out_valid_reg;
    logic              out_valid_next;
    exec_res_t         out_res_reg;

    logic              in_xfer;
    logic              s1_advance;
    logic [WORD_W-1:0] op_a;
    logic [WORD_W-1:0] op_b;
    exec_res_t         exec_res;
    rf_write_t         rf_wr;

    // Execute may move on when the output register is empty or draining.
    assign s1_advance   = s1_valid_reg && (!out_valid_reg || result.ready);
    assign instr.ready  = !s1_valid_reg || s1_advance;
    assign in_xfer      = instr.valid && instr.ready;

    msx_regfile u_regfile (
        .clk       (clk),
        .rst_n     (rst_n),
        .rd_en     (in_xfer),
        .rd_addr_a (instr.instr_word[25:21]),
        .rd_addr_b (instr.instr_word[20:16]),
        .rd_data_a (op_a),
        .rd_data_b (op_b),
        .wr        (rf_wr)
    );

    msx_exec u_exec (
        .instr_word (s1_instr_reg),
        .pc         (pc_reg),
        .op_a       (op_a),
        .op_b       (op_b),
        .res        (exec_res)
    );

    // Commit the register write only when the instruction leaves execute.
    always_comb
    begin
        rf_wr.en   = s1_advance && exec_res.reg_written;
        rf_wr.addr = exec_res.dest_reg;
        rf_wr.data = exec_res.write_value;
    end

    always_comb
    begin
        s1_valid_next  = in_xfer || (s1_valid_reg && !s1_advance);
        out_valid_next = s1_advance || (out_valid_reg && !result.ready);
        pc_next        = s1_advance ? exec_res.next_pc : pc_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            pc_reg        <= PC_RESET;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            pc_reg        <= pc_next;
        end
    end

    // Payload: load on transfer, hold otherwise.
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            s1_instr_reg <= instr.instr_word;
        end
        if (s1_advance)
        begin
            out_res_reg <= exec_res;
        end
    end

    assign result.valid       = out_valid_reg;
    assign result.next_pc     = out_res_reg.next_pc;
    assign result.reg_written = out_res_reg.reg_written;
    assign result.dest_reg    = out_res_reg.dest_reg;
    assign result.write_value = $signed(out_res_reg.write_value);
    assign result.unsupported = out_res_reg.unsupported;

    `MSEC_ASSERT_IMPL(a_no_zero_dest, clk, rst_n, result.valid && result.reg_written, result.dest_reg != '0, "write reported to register zero")
    `MSEC_ASSERT_NEXT(a_s1_hold, clk, rst_n, s1_valid_reg && !s1_advance, s1_valid_reg && $stable(s1_instr_reg), "stalled execute stage lost its instruction")
    `MSEC_ASSERT_NEXT(a_pc_hold, clk, rst_n, !s1_advance, $stable(pc_reg), "pc moved without an instruction leaving execute")
    `MSEC_ASSERT_IMPL(a_unsup_no_write, clk, rst_n, result.valid && result.unsupported, !result.reg_written, "unsupported instruction reported a write")

endmodule
